// ===== design/xtea_pkg.sv =====
// Shared types and constants for the XTEA cipher pipeline.
package xtea_pkg;

    localparam int unsigned ROUNDS    = 32;
    localparam int unsigned NUM_CELLS = 2 * ROUNDS;
    localparam logic [31:0] DELTA     = 32'h9E37_79B9;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_0      = 3'd0,
        REG_KEY_1      = 3'd1,
        REG_KEY_2      = 3'd2,
        REG_KEY_3      = 3'd3,
        REG_KEY_LOADED = 3'd4
    } t_reg_idx;

    typedef logic [3:0][31:0] t_key;

    // Block travelling along the chain
    typedef struct packed {
        logic        mode;
        logic        ok;
        logic        last;
        logic [31:0] v0;
        logic [31:0] v1;
    } t_lane;

    // Running sum seen by a half-round, truncated to 32 bits
    function automatic logic [31:0] stage_sum(input int unsigned cnt);
        logic [63:0] prod;
        prod = 64'(DELTA) * 64'(cnt);
        return prod[31:0];
    endfunction

endpackage

// ===== design/xtea_cell.sv =====
// One Feistel half-round cell of the XTEA chain, with its pipeline register.
module xtea_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_odd,
    input  logic [31:0]          i_enc_sum,
    input  logic [31:0]          i_dec_sum,
    input  xtea_pkg::t_key       i_key,
    input  logic                 i_valid,
    input  xtea_pkg::t_lane      i_lane,
    output logic                 o_valid,
    output xtea_pkg::t_lane      o_lane
);

    logic            r_valid;
    xtea_pkg::t_lane r_lane;
    xtea_pkg::t_lane n_lane;

    logic        tgt_v0;
    logic [31:0] src;
    logic [31:0] tgt;
    logic [31:0] sum;
    logic [1:0]  kidx;
    logic [31:0] mixed;
    logic [31:0] f;
    logic [31:0] res;

    // Work one half-round: target word is updated from the other word
    always_comb begin
        tgt_v0 = ~(i_odd ^ i_lane.mode);
        src    = tgt_v0 ? i_lane.v1 : i_lane.v0;
        tgt    = tgt_v0 ? i_lane.v0 : i_lane.v1;
        sum    = i_lane.mode ? i_dec_sum : i_enc_sum;
        kidx   = tgt_v0 ? sum[1:0] : sum[12:11];
        mixed  = ((src << 4) ^ (src >> 5)) + src;
        f      = mixed ^ (sum + i_key[kidx]);
        res    = i_lane.mode ? (tgt - f) : (tgt + f);
        n_lane = i_lane;
        if (i_lane.ok) begin
            if (tgt_v0) begin
                n_lane.v0 = res;
            end else begin
                n_lane.v1 = res;
            end
        end
    end

    // Hold the valid flag under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Advance the payload every cycle
    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// ===== design/xtea_block_cipher_unit.sv =====
// XTEA block cipher: a chain of half-round cells, one request per cycle.
// The result passes through 2 * ROUNDS half-round cells, one register each, before it
// is presented with its valid strobe.
// Throughput: one request per clock; busy is never raised and results cannot stall.
// Reset: synchronous active low; clears the in-flight valid flags, key and key-loaded.
// Key registers are read straight by every cell and must stay still while requests fly.
module xtea_block_cipher_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_mode,
    input  logic [31:0]                     i_word_low,
    input  logic [31:0]                     i_word_high,
    input  logic                            i_last_block,
    input  logic                            i_cfg_we,
    input  logic [xtea_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [xtea_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_valid,
    output logic [31:0]                     o_out_low,
    output logic [31:0]                     o_out_high,
    output logic                            o_ok,
    output logic                            o_last_out
);

    xtea_pkg::t_key  r_key;
    logic            r_key_loaded;
    xtea_pkg::t_lane in_lane;

    logic            chain_valid [xtea_pkg::NUM_CELLS+1];
    xtea_pkg::t_lane chain_lane  [xtea_pkg::NUM_CELLS+1];

    // Take configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key        <= '0;
            r_key_loaded <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                xtea_pkg::REG_KEY_0:      r_key[0] <= i_cfg_data;
                xtea_pkg::REG_KEY_1:      r_key[1] <= i_cfg_data;
                xtea_pkg::REG_KEY_2:      r_key[2] <= i_cfg_data;
                xtea_pkg::REG_KEY_3:      r_key[3] <= i_cfg_data;
                xtea_pkg::REG_KEY_LOADED: r_key_loaded <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Never stall the request side
    assign busy = 1'b0;

    // Pack the incoming request
    always_comb begin
        in_lane.mode = i_mode;
        in_lane.ok   = r_key_loaded;
        in_lane.last = i_last_block;
        in_lane.v0   = i_word_low;
        in_lane.v1   = i_word_high;
    end

    assign chain_valid[0] = start & ~busy;
    assign chain_lane[0]  = in_lane;

    // Build the chain; each cell knows its own running sums
    for (genvar g = 0; g < xtea_pkg::NUM_CELLS; g++) begin : g_cell
        localparam int unsigned RND = g / 2;
        localparam logic        ODD = (g % 2) == 1;
        localparam logic [31:0] ENC_SUM =
            xtea_pkg::stage_sum(ODD ? RND + 1 : RND);
        localparam logic [31:0] DEC_SUM =
            xtea_pkg::stage_sum(ODD ? xtea_pkg::ROUNDS - RND - 1 : xtea_pkg::ROUNDS - RND);

        xtea_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_odd     (ODD),
            .i_enc_sum (ENC_SUM),
            .i_dec_sum (DEC_SUM),
            .i_key     (r_key),
            .i_valid   (chain_valid[g]),
            .i_lane    (chain_lane[g]),
            .o_valid   (chain_valid[g+1]),
            .o_lane    (chain_lane[g+1])
        );
    end

    // Present the last cell's register as the result
    assign o_valid    = chain_valid[xtea_pkg::NUM_CELLS];
    assign o_out_low  = chain_lane[xtea_pkg::NUM_CELLS].v0;
    assign o_out_high = chain_lane[xtea_pkg::NUM_CELLS].v1;
    assign o_ok       = chain_lane[xtea_pkg::NUM_CELLS].ok;
    assign o_last_out = chain_lane[xtea_pkg::NUM_CELLS].last;

endmodule
